// ===== design/nau_pkg.sv =====
// Shared types, codes and constant tables for the neural activation unit.
// The sigmoid and tanh grid tables are built at elaboration by constant functions.
// No dependencies.
package nau_pkg;

  // number format and table geometry
  localparam int FracBits    = 12;
  localparam int TableDepth  = 256;
  localparam int IdxBits     = $clog2(TableDepth);
  localparam int WordBits    = 16;
  localparam int FracIdxBits = WordBits - IdxBits;
  localparam int TabW        = FracBits + 2;
  localparam int SeriesTerms = 28;
  localparam longint OneQ    = longint'(1) << FracBits;
  localparam longint unsigned Q32One = 64'd1 << 32;

  // activation kind held in the configuration register
  typedef enum logic [1:0] {
    FnSigmoid = 2'd0,
    FnTanh    = 2'd1,
    FnLinear  = 2'd2,
    FnRelu    = 2'd3
  } fn_type_e;

  // per-item operation
  typedef enum logic {
    OpActivate   = 1'b0,
    OpDerivative = 1'b1
  } op_e;

  typedef logic signed [TabW-1:0] tab_t [TableDepth+1];

  // unsigned quotient by shift and subtract, used only while building the tables
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-(r/TableDepth) in Q32, alternating series with truncated terms
  function automatic longint unsigned exp_series(longint r);
    longint term;
    longint sum;
    term = longint'(Q32One);
    sum  = 0;
    for (int n = 0; n < SeriesTerms; n++) begin
      sum  = ((n & 1) != 0) ? sum - term : sum + term;
      term = longint'(udiv(longint'(term * r), longint'(TableDepth * (n + 1))));
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // e^-(num/TableDepth) in Q32, num >= 0
  function automatic longint unsigned exp_neg(longint num);
    longint k;
    longint unsigned e1;
    longint unsigned v;
    k  = num >> IdxBits;
    e1 = exp_series(longint'(TableDepth));
    v  = exp_series(num & longint'(TableDepth - 1));
    for (longint j = 0; j < k; j++) begin
      v = (v * e1 + (64'd1 << 31)) >> 32;
    end
    return v;
  endfunction

  // grid of sigmoid or tanh over [-8, 8]
  function automatic tab_t build_tab(bit is_tanh);
    tab_t tab;
    longint n;
    longint mag;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    longint val;
    for (int i = 0; i <= TableDepth; i++) begin
      n = 16 * longint'(i) - 8 * longint'(TableDepth);
      if (is_tanh) begin
        n = 2 * n;
      end
      mag = (n < 0) ? -n : n;
      e   = exp_neg(mag);
      den = Q32One + e;
      if (is_tanh) begin
        q   = udiv(((Q32One - e) << FracBits) + (den >> 1), den);
        val = (n < 0) ? -longint'(q) : longint'(q);
      end else begin
        q   = udiv((64'd1 << (FracBits + 32)) + (den >> 1), den);
        val = (n < 0) ? OneQ - longint'(q) : longint'(q);
      end
      tab[i] = TabW'(val);
    end
    return tab;
  endfunction

  localparam tab_t SigTab  = build_tab(1'b0);
  localparam tab_t TanhTab = build_tab(1'b1);

endpackage

// ===== design/nau_eval.sv =====
// Combinational evaluation of one item: table interpolation or derivative.
// Depends on nau_pkg for codes and the constant tables.
module nau_eval (
  input  nau_pkg::fn_type_e          fn_type_i,
  input  nau_pkg::op_e               op_i,
  input  logic signed [15:0]         operand_i,
  output logic signed [15:0]         result_o
);
  import nau_pkg::*;

  logic [WordBits-1:0]        u;
  logic [IdxBits-1:0]         idx;
  logic [IdxBits:0]           idx_lo;
  logic [IdxBits:0]           idx_hi;
  logic [FracIdxBits-1:0]     frac;
  logic signed [TabW-1:0]     t0;
  logic signed [TabW-1:0]     t1;
  logic signed [TabW:0]       diff;
  logic signed [TabW+FracIdxBits+1:0] prod;
  logic signed [TabW+FracIdxBits+1:0] step;
  logic signed [TabW+1:0]     interp;
  logic signed [16:0]         one_minus;
  logic signed [32:0]         sig_prod;
  logic signed [33:0]         sig_der;
  logic signed [31:0]         sq;
  logic signed [32:0]         sq_rnd;
  logic signed [33:0]         tanh_der;
  logic signed [33:0]         res;

  // offset the operand so that -8.0 maps to grid point zero
  assign u      = {~operand_i[15], operand_i[14:0]};
  assign idx    = u[WordBits-1 -: IdxBits];
  assign frac   = u[FracIdxBits-1:0];
  assign idx_lo = {1'b0, idx};
  assign idx_hi = {1'b0, idx} + (IdxBits+1)'(1);

  // neighbouring grid points of the selected curve
  always_comb begin
    if (fn_type_i == FnTanh) begin
      t0 = TanhTab[idx_lo];
      t1 = TanhTab[idx_hi];
    end else begin
      t0 = SigTab[idx_lo];
      t1 = SigTab[idx_hi];
    end
  end

  // linear interpolation, rounded half up
  assign diff   = (TabW+1)'(t1) - (TabW+1)'(t0);
  assign prod   = (TabW+FracIdxBits+2)'(diff) *
                  (TabW+FracIdxBits+2)'($signed({1'b0, frac}));
  assign step   = (prod + (TabW+FracIdxBits+2)'(1 << (FracIdxBits-1))) >>> FracIdxBits;
  assign interp = (TabW+2)'(t0) + (TabW+2)'(step);

  // sigmoid derivative a*(1-a)
  assign one_minus = 17'(OneQ) - 17'(operand_i);
  assign sig_prod  = 33'(operand_i) * 33'(one_minus);
  assign sig_der   = (34'(sig_prod) + 34'(OneQ >> 1)) >>> FracBits;

  // tanh derivative 1-a*a
  assign sq       = 32'(operand_i) * 32'(operand_i);
  assign sq_rnd   = (33'(sq) + 33'(OneQ >> 1)) >>> FracBits;
  assign tanh_der = 34'(OneQ) - 34'(sq_rnd);

  // pick the result for the operation and kind
  always_comb begin
    if (op_i == OpActivate) begin
      unique case (fn_type_i)
        FnSigmoid, FnTanh: res = 34'(interp);
        FnLinear:          res = 34'(operand_i);
        FnRelu:            res = (operand_i > 16'sd0) ? 34'(operand_i) : 34'sd0;
        default:           res = 34'sd0;
      endcase
    end else begin
      unique case (fn_type_i)
        FnSigmoid: res = sig_der;
        FnTanh:    res = tanh_der;
        FnLinear:  res = 34'(OneQ);
        FnRelu:    res = (operand_i > 16'sd0) ? 34'(OneQ) : 34'sd0;
        default:   res = 34'sd0;
      endcase
    end
  end

  // saturate to the signed 16-bit range
  always_comb begin
    if (res > 34'sd32767) begin
      result_o = 16'sh7fff;
    end else if (res < -34'sd32768) begin
      result_o = -16'sh8000;
    end else begin
      result_o = res[15:0];
    end
  end

endmodule

// ===== design/neural_activation_unit.sv =====
// Neural activation unit: sigmoid, tanh, linear or relu on signed Q4.12 items.
// From start to result_valid_o an item passes the input register, then the result register.
// Throughput 1 item per cycle; busy is always low and results cannot be stalled.
// Reset clears the item strobes and sets the activation kind to sigmoid.
// Uses nau_pkg and nau_eval.
module neural_activation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic signed [15:0] operand_value_i,
  input  logic               function_type_we_i,
  input  logic [1:0]         function_type_i,
  output logic               result_valid_o,
  output logic signed [15:0] result_value_o
);
  import nau_pkg::*;

  fn_type_e           function_type_q;
  logic               in_valid_q;
  op_e                op_q;
  logic signed [15:0] operand_q;
  logic signed [15:0] result_d;
  logic               result_valid_q;
  logic signed [15:0] result_value_q;

  // an item can enter every cycle
  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      function_type_q <= FnSigmoid;
    end else if (function_type_we_i) begin
      function_type_q <= fn_type_e'(function_type_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q      <= op_e'(func_i);
      operand_q <= operand_value_i;
    end
  end

  nau_eval u_eval (
    .fn_type_i (function_type_q),
    .op_i      (op_q),
    .operand_i (operand_q),
    .result_o  (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_value_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_value_o = result_value_q;

endmodule
